// File: rtl/pfba_pkg.sv
// Shared constants, types and a helper function of the page frame bitmap allocator.
package pfba_pkg;

  // Bitmap geometry
  localparam int FRAME_COUNT  = 4096;
  localparam int PAGE_COUNT   = 4096;
  localparam int WORD_BITS    = 32;
  localparam int OUT_REACH    = 4096;
  localparam int SEARCH_LIMIT = (FRAME_COUNT < OUT_REACH) ? FRAME_COUNT : OUT_REACH;
  localparam int FRAME_WORDS  = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int PAGE_WORDS   = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int SCAN_WORDS   = (SEARCH_LIMIT + WORD_BITS - 1) / WORD_BITS;
  localparam int FW_AW        = $clog2(FRAME_WORDS);
  localparam int PW_AW        = $clog2(PAGE_WORDS);
  localparam int BIT_W        = $clog2(WORD_BITS);
  localparam int SCNT_W       = $clog2(SCAN_WORDS + 1);

  // Field widths
  localparam int FIELD_W  = 12;
  localparam int RES_W    = 13;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 14;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_PAGE_USED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_FRAME  = 2'd2;

  // Result of examining one frame bitmap word
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } scan_res_t;

  // Mask of the bits b of a word starting at frame base with base + b < bound
  function automatic logic [WORD_BITS-1:0] low_mask(input logic [CNT_W-1:0] bound,
                                                    input logic [CNT_W-1:0] base);
    logic [CNT_W:0]         diff;
    logic [WORD_BITS-1:0]   mask;
    diff = {1'b0, bound} - {1'b0, base};
    if (diff[CNT_W]) begin
      mask = '0;
    end else if (diff >= (CNT_W+1)'(WORD_BITS)) begin
      mask = '1;
    end else begin
      mask = ~({WORD_BITS{1'b1}} << diff[BIT_W-1:0]);
    end
    return mask;
  endfunction

endpackage

// File: rtl/page_frame_bitmap_allocator.sv
// Top level: sequencer, bitmap RAMs and row valid bits of the page frame allocator.
//
// Accepts one request when start is high and busy is low, then holds busy high until the
// result strobe. A free, or an allocate on a page already in use, reads both bitmap RAMs
// and then returns its result. An allocate that proceeds reads the frame bitmap RAM one
// word per cycle from frame 0 upward and stops at the first word with a free frame, which
// it then marks in both bitmaps; when no frame is free it returns STAT_NO_FRAME after the
// last word is checked. The result is on out_* for exactly one cycle with out_valid high;
// there is no way to hold it off, so capture it on that edge. Both bitmaps read as empty
// right after reset (per-row valid bits, no clearing pass). The user must write the
// reserved frame count over cfg_* only while idle; the block itself does not enforce it.
module page_frame_bitmap_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_cmd,
  input  logic [pfba_pkg::FIELD_W-1:0]  in_virt_page,
  input  logic [pfba_pkg::FIELD_W-1:0]  in_phys_page,
  output logic                          out_valid,
  output logic [pfba_pkg::STATUS_W-1:0] out_status,
  output logic [pfba_pkg::FIELD_W-1:0]  out_frame_out,
  output logic [pfba_pkg::FIELD_W-1:0]  out_page_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfba_pkg::RES_W-1:0]    cfg_data
);
  import pfba_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_CHK  = 6'b000100,
    S_SCAN = 6'b001000,
    S_WR   = 6'b010000,
    S_FREE = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic                  cmd_r;
  logic [FIELD_W-1:0]    vpage_r, ppage_r;
  logic [RES_W-1:0]      reserved_r;
  logic [SCNT_W-1:0]     rd_w_r, rd_w_nxt;
  logic [FW_AW-1:0]      chk_w_r, chk_w_nxt;
  logic                  data_ok_r, data_ok_nxt;
  logic [FW_AW-1:0]      fnd_w_r, fnd_w_nxt;
  logic [BIT_W-1:0]      fnd_b_r, fnd_b_nxt;
  logic [WORD_BITS-1:0]  fnd_word_r, fnd_word_nxt;
  logic [WORD_BITS-1:0]  page_word_r, page_word_nxt;
  logic [FRAME_WORDS-1:0] frm_vld_r;
  logic [PAGE_WORDS-1:0] pg_vld_r;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [FIELD_W-1:0]    out_frame_r;

  logic                  accept;
  logic                  emit;
  logic [STATUS_W-1:0]   emit_status;
  logic [FIELD_W-1:0]    emit_frame;

  logic [FW_AW-1:0]      prow;
  logic [BIT_W-1:0]      pbit;
  logic [PW_AW-1:0]      vrow;
  logic [BIT_W-1:0]      vbit;
  logic                  p_in_range, v_in_range;

  logic                  frm_we, frm_re;
  logic [FW_AW-1:0]      frm_waddr, frm_raddr;
  logic [WORD_BITS-1:0]  frm_wdata, frm_rdata;
  logic                  pg_we, pg_re;
  logic [PW_AW-1:0]      pg_waddr;
  logic [WORD_BITS-1:0]  pg_wdata, pg_rdata;

  logic [WORD_BITS-1:0]  frm_word, pg_word, scan_word;
  scan_res_t             scan_res;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // Decode request fields into row and bit positions
  assign prow       = FW_AW'(ppage_r >> BIT_W);
  assign pbit       = ppage_r[BIT_W-1:0];
  assign vrow       = PW_AW'(vpage_r >> BIT_W);
  assign vbit       = vpage_r[BIT_W-1:0];
  assign p_in_range = (32'(ppage_r) < 32'(FRAME_COUNT));
  assign v_in_range = (32'(vpage_r) < 32'(PAGE_COUNT));

  // Rows never written since reset read as all free
  assign frm_word  = frm_vld_r[prow] ? frm_rdata : '0;
  assign pg_word   = pg_vld_r[vrow] ? pg_rdata : '0;
  assign scan_word = frm_vld_r[chk_w_r] ? frm_rdata : '0;

  pfba_scan u_scan (
    .word     (scan_word),
    .word_idx (chk_w_r),
    .reserved (reserved_r),
    .res      (scan_res)
  );

  pfba_ram #(.WIDTH(WORD_BITS), .DEPTH(FRAME_WORDS)) u_frame_ram (
    .clk   (clk),
    .we    (frm_we),
    .waddr (frm_waddr),
    .wdata (frm_wdata),
    .re    (frm_re),
    .raddr (frm_raddr),
    .rdata (frm_rdata)
  );

  pfba_ram #(.WIDTH(WORD_BITS), .DEPTH(PAGE_WORDS)) u_page_ram (
    .clk   (clk),
    .we    (pg_we),
    .waddr (pg_waddr),
    .wdata (pg_wdata),
    .re    (pg_re),
    .raddr (vrow),
    .rdata (pg_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    rd_w_nxt      = rd_w_r;
    chk_w_nxt     = chk_w_r;
    data_ok_nxt   = data_ok_r;
    fnd_w_nxt     = fnd_w_r;
    fnd_b_nxt     = fnd_b_r;
    fnd_word_nxt  = fnd_word_r;
    page_word_nxt = page_word_r;
    emit          = 1'b0;
    emit_status   = STAT_OK;
    emit_frame    = '0;
    frm_re        = 1'b0;
    frm_raddr     = prow;
    frm_we        = 1'b0;
    frm_waddr     = prow;
    frm_wdata     = frm_word & ~(WORD_BITS'(1) << pbit);
    pg_re         = 1'b0;
    pg_we         = 1'b0;
    pg_waddr      = vrow;
    pg_wdata      = pg_word & ~(WORD_BITS'(1) << vbit);
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        frm_re    = 1'b1;
        pg_re     = 1'b1;
        state_nxt = (cmd_r == CMD_FREE) ? S_FREE : S_CHK;
      end
      S_FREE: begin
        frm_we      = p_in_range;
        pg_we       = v_in_range;
        emit        = 1'b1;
        emit_status = STAT_OK;
        state_nxt   = S_IDLE;
      end
      S_CHK: begin
        if (!v_in_range || pg_word[vbit]) begin
          emit        = 1'b1;
          emit_status = STAT_PAGE_USED;
          state_nxt   = S_IDLE;
        end else begin
          page_word_nxt = pg_word;
          rd_w_nxt      = '0;
          data_ok_nxt   = 1'b0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue the next word read while checking the previous one
        if (rd_w_r < SCNT_W'(SCAN_WORDS)) begin
          frm_re      = 1'b1;
          frm_raddr   = rd_w_r[FW_AW-1:0];
          rd_w_nxt    = rd_w_r + SCNT_W'(1);
          chk_w_nxt   = rd_w_r[FW_AW-1:0];
          data_ok_nxt = 1'b1;
        end else begin
          data_ok_nxt = 1'b0;
        end
        if (data_ok_r) begin
          if (scan_res.found) begin
            fnd_w_nxt    = chk_w_r;
            fnd_b_nxt    = scan_res.bit_idx;
            fnd_word_nxt = scan_word | (WORD_BITS'(1) << scan_res.bit_idx);
            state_nxt    = S_WR;
          end else if (chk_w_r == FW_AW'(SCAN_WORDS - 1)) begin
            emit        = 1'b1;
            emit_status = STAT_NO_FRAME;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_WR: begin
        frm_we      = 1'b1;
        frm_waddr   = fnd_w_r;
        frm_wdata   = fnd_word_r;
        pg_we       = 1'b1;
        pg_wdata    = page_word_r | (WORD_BITS'(1) << vbit);
        emit        = 1'b1;
        emit_status = STAT_OK;
        emit_frame  = FIELD_W'({fnd_w_r, fnd_b_r});
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      data_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
      reserved_r  <= '0;
      frm_vld_r   <= '0;
      pg_vld_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      data_ok_r   <= data_ok_nxt;
      out_valid_r <= emit;
      if (cfg_valid && cfg_ready) begin
        reserved_r <= cfg_data;
      end
      if (frm_we) begin
        frm_vld_r[frm_waddr] <= 1'b1;
      end
      if (pg_we) begin
        pg_vld_r[pg_waddr] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      vpage_r <= in_virt_page;
      ppage_r <= in_phys_page;
    end
    rd_w_r      <= rd_w_nxt;
    chk_w_r     <= chk_w_nxt;
    fnd_w_r     <= fnd_w_nxt;
    fnd_b_r     <= fnd_b_nxt;
    fnd_word_r  <= fnd_word_nxt;
    page_word_r <= page_word_nxt;
    if (emit) begin
      out_status_r <= emit_status;
      out_frame_r  <= emit_frame;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_frame_out = out_frame_r;
  assign out_page_out  = vpage_r;

`ifndef SYNTHESIS
  // A result strobe always lands back in idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe outside idle");

  // Strobes never come in two consecutive cycles
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("back-to-back result strobes");

  // An accepted request raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after accept");

  // A free word found in the scan leads to the writeback
  a_found_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && data_ok_r && scan_res.found) |=> (state_r == S_WR))
    else $error("found frame not written back");

  // Writeback always marks both bitmaps
  a_wr_both: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> (frm_we && pg_we && emit && emit_status == STAT_OK))
    else $error("incomplete allocate writeback");
`endif

endmodule

// File: rtl/pfba_ram.sv
// Generic single write port, single read port RAM with registered read data.
module pfba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/pfba_scan.sv
// Word scan unit: applies reserved and search bounds, finds the lowest free frame bit.
module pfba_scan (
  input  logic [pfba_pkg::WORD_BITS-1:0] word,
  input  logic [pfba_pkg::FW_AW-1:0]     word_idx,
  input  logic [pfba_pkg::RES_W-1:0]     reserved,
  output pfba_pkg::scan_res_t            res
);
  import pfba_pkg::*;

  logic [CNT_W-1:0]     base;
  logic [WORD_BITS-1:0] busy;

  // Merge stored marks with reserved frames and frames past the search bound
  always_comb begin
    base = CNT_W'(word_idx) << BIT_W;
    busy = word
         | low_mask(CNT_W'(reserved), base)
         | ~low_mask(CNT_W'(SEARCH_LIMIT), base);
  end

  // Priority encode the lowest clear bit
  always_comb begin
    res.found   = 1'b0;
    res.bit_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!busy[b]) begin
        res.found   = 1'b1;
        res.bit_idx = BIT_W'(b);
      end
    end
  end

endmodule

// File: verif/page_frame_bitmap_allocator_test.sv
// Self-checking testbench of the page frame bitmap allocator: directed and random traffic.
module page_frame_bitmap_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pfba_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 150;

  // One result transaction as the block should report it
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  frame;
    logic [FIELD_W-1:0]  page;
  } grant_t;

  // A virtual page and the frame it currently holds
  typedef struct {
    logic [FIELD_W-1:0] vpage;
    logic [FIELD_W-1:0] frame;
  } mapping_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_cmd = CMD_ALLOC;
  logic [FIELD_W-1:0]  in_virt_page = '0;
  logic [FIELD_W-1:0]  in_phys_page = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [FIELD_W-1:0]  out_frame_out;
  logic [FIELD_W-1:0]  out_page_out;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [RES_W-1:0]    cfg_data = '0;

  // Shadow bitmaps and reserved count
  bit       frame_taken [FRAME_COUNT];
  bit       page_taken [PAGE_COUNT];
  int       reserved_count = 0;
  grant_t   grant_queue[$];
  mapping_t live_maps[$];
  int       mismatches = 0;
  bit       idle_on = 1'b1;
  int       stall_cycles = 0;

  page_frame_bitmap_allocator uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_virt_page  (in_virt_page),
    .in_phys_page  (in_phys_page),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_frame_out (out_frame_out),
    .out_page_out  (out_page_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // Apply one request to the shadow state and return the grant it produces
  function automatic grant_t compute_grant(input logic cmd, input logic [FIELD_W-1:0] vp,
                                           input logic [FIELD_W-1:0] pp);
    grant_t g;
    int     f;
    g.status = STAT_OK;
    g.frame  = '0;
    g.page   = vp;
    if (cmd == CMD_FREE) begin
      if (pp < FRAME_COUNT) frame_taken[pp] = 1'b0;
      if (vp < PAGE_COUNT) page_taken[vp] = 1'b0;
      // drop any mapping that this free touched
      for (int i = live_maps.size() - 1; i >= 0; i--) begin
        if (live_maps[i].vpage == vp || live_maps[i].frame == pp) live_maps.delete(i);
      end
    end else if (vp >= PAGE_COUNT || page_taken[vp]) begin
      g.status = STAT_PAGE_USED;
    end else begin
      // first fit above the reserved frames
      f = reserved_count;
      while (f < SEARCH_LIMIT && frame_taken[f]) f++;
      if (f < SEARCH_LIMIT) begin
        frame_taken[f] = 1'b1;
        page_taken[vp] = 1'b1;
        g.frame = FIELD_W'(f);
        live_maps.push_back('{vpage: vp, frame: FIELD_W'(f)});
      end else begin
        g.status = STAT_NO_FRAME;
      end
    end
    return g;
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, what);
  endfunction

  // Send one request transaction; start stays high until the next one or a pause
  task automatic issue_request(input logic cmd, input logic [FIELD_W-1:0] vp,
                               input logic [FIELD_W-1:0] pp);
    while (idle_on && $urandom_range(99) < 13) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_cmd       <= cmd;
    in_virt_page <= vp;
    in_phys_page <= pp;
    do @(posedge clk); while (busy);
    grant_queue.push_back(compute_grant(cmd, vp, pp));
  endtask

  // Hold off new requests until every expected grant has arrived
  task automatic drain_grants();
    start <= 1'b0;
    do @(posedge clk); while (grant_queue.size() != 0);
  endtask

  task automatic write_reserved(input int count);
    drain_grants();
    cfg_valid <= 1'b1;
    cfg_data  <= RES_W'(count);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reserved_count = count;
  endtask

  // Allocate, collide, free and reuse the lowest frame from an empty state
  task automatic test_alloc_free();
    issue_request(CMD_ALLOC, 12'd0, 12'hFFF);
    issue_request(CMD_ALLOC, 12'hFFF, 12'd0);
    issue_request(CMD_ALLOC, 12'd0, 12'd0);
    issue_request(CMD_FREE, 12'd0, 12'd0);
    drain_grants();
    issue_request(CMD_ALLOC, 12'hAAA, 12'h555);
    issue_request(CMD_FREE, 12'h555, 12'hFFF);
    issue_request(CMD_ALLOC, 12'h555, 12'hAAA);
  endtask

  // Reserved frames read as used even after a free clears them
  task automatic test_reserved_frames();
    write_reserved(5);
    issue_request(CMD_ALLOC, 12'd100, 12'd0);
    issue_request(CMD_FREE, 12'hAAA, 12'd0);
    issue_request(CMD_ALLOC, 12'hAAA, 12'd0);
    write_reserved(0);
    issue_request(CMD_ALLOC, 12'd200, 12'd0);
  endtask

  // Run out of frames, recover one, then reserve everything
  task automatic test_frame_exhaustion();
    write_reserved(4094);
    issue_request(CMD_ALLOC, 12'd300, 12'd0);
    issue_request(CMD_ALLOC, 12'd301, 12'd0);
    issue_request(CMD_ALLOC, 12'd302, 12'd0);
    issue_request(CMD_ALLOC, 12'd302, 12'd0);
    issue_request(CMD_FREE, 12'd301, 12'd4095);
    issue_request(CMD_ALLOC, 12'd302, 12'd0);
    write_reserved(4096);
    issue_request(CMD_ALLOC, 12'd303, 12'd0);
    write_reserved(8191);
    issue_request(CMD_ALLOC, 12'd304, 12'd0);
    issue_request(CMD_ALLOC, 12'd300, 12'd0);
    issue_request(CMD_FREE, 12'd300, 12'd4094);
    issue_request(CMD_FREE, 12'd302, 12'd4095);
  endtask

  // Mostly alloc/free pairs with random pages, some collisions and stray frees
  task automatic test_random_traffic(input int reserve, input int count, input int alloc_pct);
    mapping_t m;
    int       roll;
    write_reserved(reserve);
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < alloc_pct) begin
        if (live_maps.size() != 0 && $urandom_range(99) < 12) begin
          m = live_maps[$urandom_range(live_maps.size() - 1)];
          issue_request(CMD_ALLOC, m.vpage, FIELD_W'($urandom));
        end else begin
          issue_request(CMD_ALLOC, FIELD_W'($urandom), FIELD_W'($urandom));
        end
      end else if (live_maps.size() != 0 && roll < 95) begin
        m = live_maps[$urandom_range(live_maps.size() - 1)];
        issue_request(CMD_FREE, m.vpage, m.frame);
      end else begin
        issue_request(CMD_FREE, FIELD_W'($urandom), FIELD_W'($urandom));
      end
      if ($urandom_range(59) == 0) drain_grants();
    end
  endtask

  // Compare each result transaction with the oldest expected grant
  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_valid) begin
      if (grant_queue.size() == 0) begin
        note_mismatch($sformatf("unexpected result status %0d frame %0d page %0d",
                                out_status, out_frame_out, out_page_out));
      end else begin
        want = grant_queue.pop_front();
        if (out_status !== want.status)
          note_mismatch($sformatf("page %0d status expected %0d actual %0d",
                                  want.page, want.status, out_status));
        if (out_frame_out !== want.frame)
          note_mismatch($sformatf("page %0d frame expected %0d actual %0d",
                                  want.page, want.frame, out_frame_out));
        if (out_page_out !== want.page)
          note_mismatch($sformatf("page expected %0d actual %0d", want.page, out_page_out));
      end
    end
  end

  // Stop the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_alloc_free();
    test_reserved_frames();
    test_frame_exhaustion();
    test_random_traffic(0, 250, 60);
    idle_on = 1'b0;
    test_random_traffic(0, 300, 50);
    idle_on = 1'b1;
    test_random_traffic(37, 250, 55);
    test_random_traffic(4032, 250, 70);
    test_random_traffic(4095, 100, 50);
    test_random_traffic(8191, 60, 50);
    test_random_traffic(0, 300, 45);
    drain_grants();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && grant_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
